### src/expiring_increment_counter_macros.svh
// assertion macros for the expiring increment counter
`ifndef EXPIRING_INCREMENT_COUNTER_MACROS_SVH
`define EXPIRING_INCREMENT_COUNTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define EIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define EIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/eic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eic_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  // fixed field widths
  localparam int STEP_W    = 8;
  localparam int IN_TIME_W = 32;
  localparam int COUNT_W   = 32;
  localparam int CV_W      = 16;
  localparam int IN_DATA_W = 72;
  localparam int IN_USER_W = 2;
  localparam int OUT_USER_W = 2;

  // opcodes
  localparam logic OP_INC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // bit positions in tuser
  localparam int IU_OPCODE = 0;
  localparam int IU_NEVER  = 1;
  localparam int OU_ZERO   = 0;
  localparam int OU_REJ    = 1;

  // count update requested from the shared unit
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    acc_op_t           op;
    logic [STEP_W-1:0] step;
  } unit_ctrl_t;

endpackage

`default_nettype wire

### src/eic_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module eic_slot_ram #(
  parameter int DEPTH = eic_pkg::QUEUE_DEPTH_DEF,
  parameter int WIDTH = eic_pkg::TIME_BITS_DEF + eic_pkg::STEP_W
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/eic_cmp_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module eic_cmp_unit #(
  parameter int TIME_BITS = eic_pkg::TIME_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire eic_pkg::unit_ctrl_t          ctrl,
  input  wire logic [TIME_BITS-1:0]         key,
  input  wire logic [TIME_BITS-1:0]         slot_expiry,
  output logic                              le,
  output logic [eic_pkg::COUNT_W-1:0]       count
);

  logic [eic_pkg::COUNT_W-1:0] count_r;
  logic [eic_pkg::COUNT_W-1:0] count_nxt;

  // shared expiry compare: slot at or before key
  assign le = (slot_expiry <= key);

  // running count, wraps on add and subtract
  always_comb begin
    count_nxt = count_r;
    case (ctrl.op)
      eic_pkg::ACC_ADD: count_nxt = count_r + eic_pkg::COUNT_W'(ctrl.step);
      eic_pkg::ACC_SUB: count_nxt = count_r - eic_pkg::COUNT_W'(ctrl.step);
      default:          count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

`default_nettype wire

### src/expiring_increment_counter.sv
// Expiring increment counter with a sorted store of timed increments.
// Input channel in_*: in_tuser marks an increment or a read and whether the
// increment is permanent; in_tdata carries step, expiry time and current time.
// Output channel out_*: exactly one result transfer per input transfer, in
// order; out_tdata holds the low 16 bits of the count on reads, out_tuser the
// zero and rejected flags.
// One item is handled at a time; in_tready is high only while the sequencer
// is idle. The walk over the slot store visits each slot with a memory read,
// then a compare and write: a permanent or rejected increment makes no walk,
// a timed increment walks back over the entries with a later expiry, and a
// read walks over the entries that it clears.
// A finished result sits in the output register; the next item may be taken
// meanwhile, but its result waits until out_tready drains the register.
// Reset (rst_n low, synchronous) clears the count, the slot count, head and tail;
// store contents need no clearing and are read only once written.
`timescale 1ns / 1ps
`default_nettype none
`include "expiring_increment_counter_macros.svh"

module expiring_increment_counter #(
  parameter int QUEUE_DEPTH = eic_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = eic_pkg::TIME_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [7:0] step, [39:8] expiry_time, [71:40] now
  input  wire logic [eic_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] opcode, [1] never_expires
  input  wire logic [eic_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] count_value
  output logic [eic_pkg::CV_W-1:0]               out_tdata,
  // [0] is_zero, [1] rejected
  output logic [eic_pkg::OUT_USER_W-1:0]         out_tuser
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W = TIME_BITS + eic_pkg::STEP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_CLR_RD,
    S_CLR_CMP,
    S_DONE
  } state_t;

  // ring pointer helpers
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    ptr_prev = (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
  endfunction

  // input field split
  logic [eic_pkg::STEP_W-1:0]    in_step;
  logic [eic_pkg::IN_TIME_W-1:0] in_expiry;
  logic [eic_pkg::IN_TIME_W-1:0] in_now;
  logic                          in_opcode;
  logic                          in_never;

  assign in_step   = in_tdata[7:0];
  assign in_expiry = in_tdata[39:8];
  assign in_now    = in_tdata[71:40];
  assign in_opcode = in_tuser[eic_pkg::IU_OPCODE];
  assign in_never  = in_tuser[eic_pkg::IU_NEVER];

  // registers
  state_t                          state_r, state_nxt;
  logic                            op_r, op_nxt;
  logic [eic_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [TIME_BITS-1:0]            key_r, key_nxt;
  logic                            rej_r, rej_nxt;
  logic [PTR_W-1:0]                head_r, head_nxt;
  logic [PTR_W-1:0]                tail_r, tail_nxt;
  logic [PTR_W-1:0]                wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]                used_r, used_nxt;
  logic [CNT_W-1:0]                rem_r, rem_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [eic_pkg::CV_W-1:0]        out_data_r, out_data_nxt;
  logic [eic_pkg::OUT_USER_W-1:0]  out_user_r, out_user_nxt;

  // store and shared unit wiring
  logic              mem_wr_en;
  logic [PTR_W-1:0]  mem_wr_addr;
  logic [SLOT_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [PTR_W-1:0]  mem_rd_addr;
  logic [SLOT_W-1:0] mem_rd_data;

  eic_pkg::unit_ctrl_t         uctrl;
  logic                        slot_le;
  logic [eic_pkg::COUNT_W-1:0] count;

  logic in_xfer;
  logic out_load;

  eic_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (SLOT_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  eic_cmp_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp_unit (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (uctrl),
    .key         (key_r),
    .slot_expiry (mem_rd_data[SLOT_W-1:eic_pkg::STEP_W]),
    .le          (slot_le),
    .count       (count)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    step_nxt      = step_r;
    key_nxt       = key_r;
    rej_nxt       = rej_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    wr_ptr_nxt    = wr_ptr_r;
    used_nxt      = used_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    mem_wr_en   = 1'b0;
    mem_wr_addr = wr_ptr_r;
    mem_wr_data = {key_r, step_r};
    mem_rd_en   = 1'b0;
    mem_rd_addr = head_r;
    uctrl.op    = eic_pkg::ACC_HOLD;
    uctrl.step  = step_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt   = in_opcode;
          step_nxt = in_step;
          key_nxt  = (in_opcode == eic_pkg::OP_READ) ? TIME_BITS'(in_now)
                                                     : TIME_BITS'(in_expiry);
          rej_nxt  = 1'b0;
          if (in_opcode == eic_pkg::OP_READ) begin
            state_nxt = S_CLR_RD;
          end else if (in_never) begin
            uctrl.op   = eic_pkg::ACC_ADD;
            uctrl.step = in_step;
            state_nxt  = S_DONE;
          end else if (used_r == CNT_W'(QUEUE_DEPTH)) begin
            rej_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            uctrl.op   = eic_pkg::ACC_ADD;
            uctrl.step = in_step;
            rem_nxt    = used_r;
            wr_ptr_nxt = tail_r;
            state_nxt  = S_INS_RD;
          end
        end
      end

      // walk back from the tail, reading the entry before the hole
      S_INS_RD: begin
        if (rem_r == '0) begin
          mem_wr_en = 1'b1;
          used_nxt  = used_r + CNT_W'(1);
          tail_nxt  = ptr_next(tail_r);
          state_nxt = S_DONE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_prev(wr_ptr_r);
          state_nxt   = S_INS_CMP;
        end
      end

      // later expiry moves up one slot, otherwise the new entry fills the hole
      S_INS_CMP: begin
        mem_wr_en = 1'b1;
        if (!slot_le) begin
          mem_wr_data = mem_rd_data;
          wr_ptr_nxt  = ptr_prev(wr_ptr_r);
          rem_nxt     = rem_r - CNT_W'(1);
          state_nxt   = S_INS_RD;
        end else begin
          used_nxt  = used_r + CNT_W'(1);
          tail_nxt  = ptr_next(tail_r);
          state_nxt = S_DONE;
        end
      end

      // read the head entry, the one with the earliest expiry
      S_CLR_RD: begin
        if (used_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = head_r;
          state_nxt   = S_CLR_CMP;
        end
      end

      // expired entry leaves the head and its step comes off the count
      S_CLR_CMP: begin
        if (slot_le) begin
          uctrl.op   = eic_pkg::ACC_SUB;
          uctrl.step = mem_rd_data[eic_pkg::STEP_W-1:0];
          head_nxt   = ptr_next(head_r);
          used_nxt   = used_r - CNT_W'(1);
          state_nxt  = S_CLR_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (op_r == eic_pkg::OP_READ) begin
            out_data_nxt                  = count[eic_pkg::CV_W-1:0];
            out_user_nxt[eic_pkg::OU_ZERO] = (count[eic_pkg::CV_W-1:0] == '0);
          end else begin
            out_data_nxt                  = '0;
            out_user_nxt[eic_pkg::OU_ZERO] = 1'b0;
          end
          out_user_nxt[eic_pkg::OU_REJ] = rej_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    step_r     <= step_nxt;
    key_r      <= key_nxt;
    rej_r      <= rej_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks
  `EIC_ASSERT_IMP(a_used_range, 1'b1, used_r <= CNT_W'(QUEUE_DEPTH), "slot count beyond depth")
  `EIC_ASSERT_IMP(a_ring_empty, used_r == '0, head_r == tail_r, "empty store with head off tail")
  `EIC_ASSERT_IMP(a_rej_full, out_load && rej_r, used_r == CNT_W'(QUEUE_DEPTH), "reject while not full")
  `EIC_ASSERT_NXT(a_one_item, in_xfer, !in_tready, "second item taken while busy")

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import eic_pkg::*;

  localparam int DEPTH      = QUEUE_DEPTH_DEF;
  localparam int RAND_ITEMS = 400;
  // no idling once the backlog is this short
  localparam int TAIL_ITEMS = 40;
  localparam int MAX_SHOWN  = 10;

  // one command as the sender sees it
  typedef struct packed {
    logic                 op;
    logic                 never;
    logic [STEP_W-1:0]    step;
    logic [IN_TIME_W-1:0] expiry;
    logic [IN_TIME_W-1:0] now;
  } cmd_t;

  // one result transfer
  typedef struct packed {
    logic [CV_W-1:0] count_value;
    logic            is_zero;
    logic            rejected;
  } resp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [CV_W-1:0]       out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  // commands still to send, results still owed
  cmd_t  cmd_backlog[$];
  resp_t owed_resp[$];
  cmd_t  cmd_on_bus;

  // shadow of the counter and its sorted timeout store
  logic [COUNT_W-1:0]   shadow_count = '0;
  logic [IN_TIME_W-1:0] shadow_expiry [DEPTH];
  logic [STEP_W-1:0]    shadow_step [DEPTH];
  int                   shadow_fill = 0;
  int                   peak_fill = 0;

  int in_gap = 0;
  int out_gap = 0;
  bit idle_ok;
  int mismatches = 0;
  int resp_seen = 0;
  int reads_seen = 0;
  int rejects_seen = 0;
  int zeros_seen = 0;

  expiring_increment_counter #(
    .QUEUE_DEPTH(QUEUE_DEPTH_DEF),
    .TIME_BITS  (TIME_BITS_DEF)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // updates the shadow state for one accepted command and gives its result
  function automatic resp_t count_after(cmd_t c);
    resp_t              r;
    int                 pos;
    int                 k;
    logic [COUNT_W-1:0] freed;
    r = '0;
    if (c.op == OP_INC) begin
      if (!c.never) begin
        // full store drops the whole increment
        if (shadow_fill >= DEPTH) begin
          r.rejected = 1'b1;
          return r;
        end
        // equal expiry goes after the ones already stored
        pos = 0;
        while (pos < shadow_fill && shadow_expiry[pos] <= c.expiry) pos++;
        for (k = shadow_fill; k > pos; k--) begin
          shadow_expiry[k] = shadow_expiry[k-1];
          shadow_step[k]   = shadow_step[k-1];
        end
        shadow_expiry[pos] = c.expiry;
        shadow_step[pos]   = c.step;
        shadow_fill++;
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      end
      shadow_count = shadow_count + c.step;
      return r;
    end
    // read: drop the expired head of the store
    freed = '0;
    k = 0;
    while (k < shadow_fill && shadow_expiry[k] <= c.now) begin
      freed = freed + shadow_step[k];
      k++;
    end
    for (pos = k; pos < shadow_fill; pos++) begin
      shadow_expiry[pos-k] = shadow_expiry[pos];
      shadow_step[pos-k]   = shadow_step[pos];
    end
    shadow_fill  = shadow_fill - k;
    shadow_count = shadow_count - freed;
    r.count_value = shadow_count[CV_W-1:0];
    r.is_zero     = (shadow_count[CV_W-1:0] == '0);
    return r;
  endfunction

  function automatic cmd_t mk_cmd(logic op, logic [STEP_W-1:0] step,
                                  logic [IN_TIME_W-1:0] expiry, logic never,
                                  logic [IN_TIME_W-1:0] now);
    cmd_t c;
    c.op     = op;
    c.step   = step;
    c.expiry = expiry;
    c.never  = never;
    c.now    = now;
    return c;
  endfunction

  function automatic void report_bad(string what, resp_t want, resp_t got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("%s at result %0d: expected count=%h zero=%b rej=%b, got count=%h zero=%b rej=%b",
               what, resp_seen, want.count_value, want.is_zero, want.rejected,
               got.count_value, got.is_zero, got.rejected);
  endfunction

  // input driver: predicts on each transfer, then offers the next command
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      idle_ok = (cmd_backlog.size() > TAIL_ITEMS);
      if (in_tvalid && in_tready) begin
        if (cmd_on_bus.op == OP_READ) reads_seen++;
        owed_resp.push_back(count_after(cmd_on_bus));
      end
      if (in_gap > 0) in_gap--;
      else if (idle_ok && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 4);
      if (!in_tvalid || in_tready) begin
        if (in_gap == 0 && cmd_backlog.size() > 0) begin
          cmd_on_bus = cmd_backlog.pop_front();
          in_tdata  <= {cmd_on_bus.now, cmd_on_bus.expiry, cmd_on_bus.step};
          in_tuser  <= {cmd_on_bus.never, cmd_on_bus.op};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    resp_t got;
    resp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.count_value = out_tdata;
        got.is_zero     = out_tuser[OU_ZERO];
        got.rejected    = out_tuser[OU_REJ];
        if (owed_resp.size() == 0) begin
          report_bad("unexpected result", '0, got);
        end else begin
          want = owed_resp.pop_front();
          if (got.count_value !== want.count_value || got.is_zero !== want.is_zero ||
              got.rejected !== want.rejected)
            report_bad("mismatch", want, got);
        end
        resp_seen++;
        if (got.rejected) rejects_seen++;
        if (got.is_zero) zeros_seen++;
      end
      if (out_gap > 0) out_gap--;
      else if (cmd_backlog.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
        out_gap = $urandom_range(1, 4);
      out_tready <= (out_gap == 0);
    end
  end

  // stimulus and end of run
  initial begin
    logic [IN_TIME_W-1:0] tnow;
    logic [IN_TIME_W-1:0] exp_t;
    logic [IN_TIME_W-1:0] last_exp;
    int                   n;
    int                   k;
    int                   burst;

    // empty read, then a permanent maximum step
    cmd_backlog.push_back(mk_cmd(OP_READ, 8'($urandom), $urandom, 1'b1, '0));
    cmd_backlog.push_back(mk_cmd(OP_INC, 8'hFF, '1, 1'b1, '1));
    // zero step expiring at time zero, cleared by a read at zero
    cmd_backlog.push_back(mk_cmd(OP_INC, 8'h00, '0, 1'b0, $urandom));
    cmd_backlog.push_back(mk_cmd(OP_READ, 8'($urandom), $urandom, 1'b0, '0));
    // fill the store: equal expiries, latest possible expiry, falling order
    for (k = 0; k < DEPTH; k++) begin
      if (k < 4) exp_t = 100;
      else if (k == 4) exp_t = '1;
      else exp_t = 300 - 20 * k;
      cmd_backlog.push_back(mk_cmd(OP_INC, 8'(k * 17), exp_t, 1'b0, $urandom));
    end
    // full store: timed one dropped, permanent one still taken
    cmd_backlog.push_back(mk_cmd(OP_INC, 8'h55, 50, 1'b0, $urandom));
    cmd_backlog.push_back(mk_cmd(OP_INC, 8'hAA, 50, 1'b1, $urandom));
    // partial clear, the equal-expiry group together, then everything
    cmd_backlog.push_back(mk_cmd(OP_READ, 8'($urandom), $urandom, 1'b0, 99));
    cmd_backlog.push_back(mk_cmd(OP_READ, 8'($urandom), $urandom, 1'b1, 100));
    cmd_backlog.push_back(mk_cmd(OP_READ, 8'($urandom), $urandom, 1'b0, '1));

    // random traffic: bursts of mostly timed increments near a moving clock, then reads
    n = 0;
    tnow = $urandom_range(0, 1000);
    last_exp = tnow;
    while (n < RAND_ITEMS) begin
      burst = $urandom_range(1, 20);
      for (k = 0; k < burst; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          cmd_backlog.push_back(mk_cmd(1'($urandom), 8'($urandom), $urandom, 1'($urandom),
                                       $urandom));
        end else begin
          if (k > 0 && $urandom_range(0, 3) == 0) exp_t = last_exp;
          else if ($urandom_range(0, 19) == 0) exp_t = $urandom;
          else exp_t = tnow + $urandom_range(0, 400);
          last_exp = exp_t;
          cmd_backlog.push_back(mk_cmd(OP_INC, 8'($urandom_range(0, 255)), exp_t,
                                       $urandom_range(0, 7) == 0, $urandom));
        end
        n++;
      end
      burst = $urandom_range(1, 3);
      for (k = 0; k < burst; k++) begin
        if ($urandom_range(0, 24) == 0) tnow = $urandom;
        else tnow = tnow + $urandom_range(0, 150);
        cmd_backlog.push_back(mk_cmd(OP_READ, 8'($urandom), $urandom, 1'($urandom), tnow));
        n++;
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() > 0 || in_tvalid) @(posedge clk);
    while (owed_resp.size() > 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);

    $display("%0d results checked: %0d reads, %0d rejected increments, %0d zero counts",
             resp_seen, reads_seen, rejects_seen, zeros_seen);
    $display("timeout store peaked at %0d of %0d slots, %0d mismatches",
             peak_fill, DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
